FILE: hdl/msblt_pkg.sv
// shared types and constants of the masked sprite blitter
// field offsets of the stream items, action codes and frame geometry
// no dependencies
`timescale 1ns / 1ps

package msblt_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE_ROW = 2'd0,
    ACT_CLEAR     = 2'd1,
    ACT_DRAW      = 2'd2,
    ACT_READ      = 2'd3
  } action_e;

  localparam int unsigned WORD_W       = 16;
  localparam int unsigned SPRITE_W     = 64;
  localparam int unsigned FRAME_W      = 512;
  localparam int unsigned ROW_WORDS    = 32;
  localparam int unsigned COL_W        = 5;
  localparam int unsigned SHIFT_W      = 4;
  localparam int unsigned WSEL_W       = 3;
  localparam int unsigned SLOT_W       = 4;
  localparam int unsigned SROW_W       = 6;
  localparam int unsigned POS_W        = 9;
  localparam int unsigned WADDR_IN_W   = 14;

  localparam logic [WORD_W-1:0]  SHIFT_MASK = 16'h000F;
  localparam logic [WORD_W-1:0]  WORD_ONES  = 16'hFFFF;
  localparam logic [WORD_W-1:0]  WORD_ZEROS = 16'h0000;

  // input tdata layout, lowest bit first
  localparam int unsigned IN_TDATA_W   = 176;
  localparam int unsigned OFS_SLOT     = 0;
  localparam int unsigned OFS_SROW     = 4;
  localparam int unsigned OFS_COLOUR   = 10;
  localparam int unsigned OFS_ALPHA    = 74;
  localparam int unsigned OFS_WHITE    = 138;
  localparam int unsigned OFS_POS_X    = 139;
  localparam int unsigned OFS_POS_Y    = 148;
  localparam int unsigned OFS_WADDR    = 157;

  // output tdata layout
  localparam int unsigned OUT_TDATA_W  = 24;

  localparam logic [POS_W-1:0] POS_X_MAX = POS_W'(FRAME_W - SPRITE_W);

endpackage

FILE: hdl/masked_sprite_blitter_1bpp_unit.sv
// top level of the one-bit masked sprite blitter: sequencer, stores, blend unit
// depends on msblt_pkg, msblt_sprite_mem, msblt_frame_mem, msblt_blend
`timescale 1ns / 1ps

// Usage: one action per input item on the s_axis channel (action in tuser),
// exactly one result item per action on the m_axis channel.
// Actions: write a sprite row, clear the frame, draw a sprite, read a frame word.
// s_axis_tready is high only while the sequencer is idle; one item is worked
// on at a time.
// Path of each action from acceptance to m_axis_tvalid,
// with the output register free:
//   sprite row write: stored on acceptance, then S_RESP
//   frame word read: registered store read, then S_READ, then S_RESP
//   clear: S_CLEAR, one frame word written per cycle, then S_RESP
//   draw: S_DRAW, then S_FLUSH, then S_RESP; 4 words per sprite row for a
//     column-aligned x, else 5; the single frame store port pair does one
//     read-modify-write of a word per cycle, pipelined through the shared
//     shift and blend unit; a refused draw goes straight to S_RESP
// The result sits in an output register; a new item is accepted while it waits.
// If the receiver stalls, a finished action holds in its response state until
// the output register is free.
// Reset clears the control state only; sprite and frame contents are undefined
// until written.

module masked_sprite_blitter_1bpp_unit
  import msblt_pkg::*;
#(
  parameter int unsigned SPRITE_SLOTS = 16,
  parameter int unsigned FRAME_ROWS   = 512,
  parameter int unsigned SPRITE_ROWS  = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // sprite_index, sprite_row, color_bits, alpha_bits, background_white,
  // pos_x, pos_y, word_address, zero fill
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // action
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // read_data, placement_error, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned SDEPTH  = SPRITE_SLOTS * 64;
  localparam int unsigned SAW     = $clog2(SDEPTH);
  localparam int unsigned FDEPTH  = FRAME_ROWS * ROW_WORDS;
  localparam int unsigned FAW     = $clog2(FDEPTH);
  localparam int unsigned RYW     = FAW - COL_W;
  localparam logic [FAW-1:0]    FLAST   = FAW'(FDEPTH - 1);
  localparam logic [SROW_W-1:0] RLAST   = SROW_W'(SPRITE_ROWS - 1);
  localparam logic [10:0]       POS_Y_MAX = 11'(FRAME_ROWS - SPRITE_ROWS);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLEAR = 6'b000010,
    S_DRAW  = 6'b000100,
    S_FLUSH = 6'b001000,
    S_READ  = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // input fields
  action_e             in_action;
  logic [SLOT_W-1:0]   in_slot;
  logic [SROW_W-1:0]   in_srow;
  logic [SPRITE_W-1:0] in_colour;
  logic [SPRITE_W-1:0] in_alpha;
  logic                in_white;
  logic [POS_W-1:0]    in_pos_x;
  logic [POS_W-1:0]    in_pos_y;
  logic [WADDR_IN_W-1:0] in_waddr;

  assign in_action = action_e'(s_axis_tuser);
  assign in_slot   = s_axis_tdata[OFS_SLOT +: SLOT_W];
  assign in_srow   = s_axis_tdata[OFS_SROW +: SROW_W];
  assign in_colour = s_axis_tdata[OFS_COLOUR +: SPRITE_W];
  assign in_alpha  = s_axis_tdata[OFS_ALPHA +: SPRITE_W];
  assign in_white  = s_axis_tdata[OFS_WHITE];
  assign in_pos_x  = s_axis_tdata[OFS_POS_X +: POS_W];
  assign in_pos_y  = s_axis_tdata[OFS_POS_Y +: POS_W];
  assign in_waddr  = s_axis_tdata[OFS_WADDR +: WADDR_IN_W];

  logic accept;
  logic slot_ok;
  logic srow_ok;
  logic pos_bad;
  logic waddr_ok;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign slot_ok       = 9'(in_slot) < 9'(SPRITE_SLOTS);
  assign srow_ok       = 7'(in_srow) < 7'(SPRITE_ROWS);
  assign pos_bad       = (in_pos_x > POS_X_MAX) || (11'(in_pos_y) > POS_Y_MAX);
  assign waddr_ok      = 16'(in_waddr) < 16'(FDEPTH);

  // sequencer registers
  logic [FAW-1:0]     cnt_q, cnt_d;
  logic               white_q, white_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [SHIFT_W-1:0] sh_q, sh_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [POS_W-1:0]   y_q, y_d;
  logic [SROW_W-1:0]  r_q, r_d;
  logic [WSEL_W-1:0]  k_q, k_d;
  logic [WORD_W-1:0]  res_data_q, res_data_d;
  logic               res_err_q, res_err_d;

  // blend pipeline stage
  logic               pv_q, pv_d;
  logic [FAW-1:0]     paddr_q;
  logic [WSEL_W-1:0]  pk_q;

  // output register
  logic               m_valid_q, m_valid_d;
  logic [WORD_W-1:0]  m_data_q, m_data_d;
  logic               m_err_q, m_err_d;

  logic [WSEL_W-1:0]  k_last;
  logic [9:0]         row_sum;
  logic [FAW-1:0]     draw_addr;
  logic               out_free;

  assign k_last    = (sh_q != '0) ? 3'd4 : 3'd3;
  assign row_sum   = 10'(y_q) + 10'(r_q);
  assign draw_addr = {RYW'(row_sum), COL_W'(col_q + COL_W'(k_q))};
  assign out_free  = !m_valid_q || m_axis_tready;

  // store ports
  logic                sp_we;
  logic [SAW-1:0]      sp_waddr;
  logic [SAW-1:0]      sp_raddr;
  logic [SPRITE_W-1:0] sp_colour;
  logic [SPRITE_W-1:0] sp_alpha;
  logic                fr_we;
  logic [FAW-1:0]      fr_waddr;
  logic [WORD_W-1:0]   fr_wdata;
  logic [FAW-1:0]      fr_raddr;
  logic [WORD_W-1:0]   fr_rdata;
  logic [WORD_W-1:0]   blend_word;

  assign sp_we    = accept && (in_action == ACT_WRITE_ROW) && slot_ok && srow_ok;
  assign sp_waddr = SAW'({in_slot, in_srow});
  assign sp_raddr = SAW'({slot_q, r_q});

  assign fr_we    = (state_q == S_CLEAR) || pv_q;
  assign fr_waddr = (state_q == S_CLEAR) ? cnt_q : paddr_q;
  assign fr_wdata = (state_q == S_CLEAR) ? (white_q ? WORD_ONES : WORD_ZEROS) : blend_word;
  assign fr_raddr = (state_q == S_IDLE) ? FAW'(in_waddr) : draw_addr;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    white_d    = white_q;
    slot_d     = slot_q;
    sh_d       = sh_q;
    col_d      = col_q;
    y_d        = y_q;
    r_d        = r_q;
    k_d        = k_q;
    res_data_d = res_data_q;
    res_err_d  = res_err_q;
    pv_d       = 1'b0;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;
    m_err_d    = m_err_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_data_d = WORD_ZEROS;
          res_err_d  = 1'b0;
          case (in_action)
            ACT_CLEAR: begin
              white_d = in_white;
              cnt_d   = '0;
              state_d = S_CLEAR;
            end
            ACT_DRAW: begin
              slot_d  = in_slot;
              sh_d    = SHIFT_W'(16'(in_pos_x) & SHIFT_MASK);
              col_d   = in_pos_x[POS_W-1:SHIFT_W];
              y_d     = in_pos_y;
              r_d     = '0;
              k_d     = '0;
              if (pos_bad) begin
                res_err_d = 1'b1;
                state_d   = S_RESP;
              end else if (slot_ok) begin
                state_d = S_DRAW;
              end else begin
                state_d = S_RESP;
              end
            end
            ACT_READ: begin
              state_d = waddr_ok ? S_READ : S_RESP;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == FLAST) begin
          state_d = S_RESP;
        end
      end
      S_DRAW: begin
        pv_d = 1'b1;
        if (k_q == k_last) begin
          k_d = '0;
          r_d = r_q + 1'b1;
          if (r_q == RLAST) begin
            state_d = S_FLUSH;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_FLUSH: begin
        state_d = S_RESP;
      end
      S_READ: begin
        res_data_d = fr_rdata;
        state_d    = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = res_data_q;
          m_err_d   = res_err_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pv_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pv_q      <= pv_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    white_q    <= white_d;
    slot_q     <= slot_d;
    sh_q       <= sh_d;
    col_q      <= col_d;
    y_q        <= y_d;
    r_q        <= r_d;
    k_q        <= k_d;
    res_data_q <= res_data_d;
    res_err_q  <= res_err_d;
    paddr_q    <= draw_addr;
    pk_q       <= k_q;
    m_data_q   <= m_data_d;
    m_err_q    <= m_err_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, m_err_q, m_data_q};

  msblt_sprite_mem #(
    .DEPTH(SDEPTH),
    .AW   (SAW)
  ) u_sprite_mem (
    .clk_i    (clk_i),
    .we_i     (sp_we),
    .waddr_i  (sp_waddr),
    .wcolour_i(in_colour),
    .walpha_i (in_alpha),
    .raddr_i  (sp_raddr),
    .rcolour_o(sp_colour),
    .ralpha_o (sp_alpha)
  );

  msblt_frame_mem #(
    .DEPTH(FDEPTH),
    .AW   (FAW)
  ) u_frame_mem (
    .clk_i  (clk_i),
    .we_i   (fr_we),
    .waddr_i(fr_waddr),
    .wdata_i(fr_wdata),
    .raddr_i(fr_raddr),
    .rdata_o(fr_rdata)
  );

  msblt_blend u_blend (
    .colour_i(sp_colour),
    .alpha_i (sp_alpha),
    .frame_i (fr_rdata),
    .shift_i (sh_q),
    .word_i  (pk_q),
    .word_o  (blend_word)
  );

endmodule

FILE: hdl/msblt_sprite_mem.sv
// sprite store: colour and alpha bits of every sprite row side by side
// one write and one registered read per cycle; uses msblt_pkg
`timescale 1ns / 1ps

module msblt_sprite_mem
  import msblt_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic [SPRITE_W-1:0] wcolour_i,
  input  logic [SPRITE_W-1:0] walpha_i,
  input  logic [AW-1:0]       raddr_i,
  output logic [SPRITE_W-1:0] rcolour_o,
  output logic [SPRITE_W-1:0] ralpha_o
);

  logic [2*SPRITE_W-1:0] mem [DEPTH];
  logic [2*SPRITE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {walpha_i, wcolour_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rcolour_o = rdata_q[SPRITE_W-1:0];
  assign ralpha_o  = rdata_q[2*SPRITE_W-1:SPRITE_W];

endmodule

FILE: hdl/msblt_frame_mem.sv
// framebuffer store of 16-bit words, row times 32 plus column word
// one write and one registered read per cycle; uses msblt_pkg
`timescale 1ns / 1ps

module msblt_frame_mem
  import msblt_pkg::*;
#(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = 14
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/msblt_blend.sv
// shared shift and blend unit: picks one word of a sprite row shifted into
// an 80-bit window and blends it over a frame word; uses msblt_pkg
`timescale 1ns / 1ps

module msblt_blend
  import msblt_pkg::*;
(
  input  logic [SPRITE_W-1:0] colour_i,
  input  logic [SPRITE_W-1:0] alpha_i,
  input  logic [WORD_W-1:0]   frame_i,
  input  logic [SHIFT_W-1:0]  shift_i,
  input  logic [WSEL_W-1:0]   word_i,
  output logic [WORD_W-1:0]   word_o
);

  localparam int unsigned WIN_W = SPRITE_W + WORD_W;

  logic [WIN_W-1:0]  colour_win;
  logic [WIN_W-1:0]  alpha_win;
  logic [WORD_W-1:0] colour_word;
  logic [WORD_W-1:0] alpha_word;

  assign colour_win = {colour_i, WORD_ZEROS} >> shift_i;
  assign alpha_win  = {alpha_i, WORD_ZEROS} >> shift_i;

  always_comb begin
    case (word_i)
      3'd0:    begin
        colour_word = colour_win[79:64];
        alpha_word  = alpha_win[79:64];
      end
      3'd1:    begin
        colour_word = colour_win[63:48];
        alpha_word  = alpha_win[63:48];
      end
      3'd2:    begin
        colour_word = colour_win[47:32];
        alpha_word  = alpha_win[47:32];
      end
      3'd3:    begin
        colour_word = colour_win[31:16];
        alpha_word  = alpha_win[31:16];
      end
      default: begin
        colour_word = colour_win[15:0];
        alpha_word  = alpha_win[15:0];
      end
    endcase
  end

  assign word_o = (frame_i & ~alpha_word) | (colour_word & alpha_word);

endmodule
